FILE: src/proxy_v2_binary_header_parser_unit_defines.svh
// assertion helpers for the proxy v2 header parser
`ifndef PROXY_V2_BINARY_HEADER_PARSER_UNIT_DEFINES_SVH
`define PROXY_V2_BINARY_HEADER_PARSER_UNIT_DEFINES_SVH

// same-cycle implication, checked outside reset
`define PVHP_ASSERT_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("pvhp check failed");

// next-cycle implication, checked outside reset
`define PVHP_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("pvhp check failed");

`endif

FILE: src/pvhp_pkg.sv
`timescale 1ns / 1ps
package pvhp_pkg;

  // result status codes
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_PROTO = 2'd1;
  localparam logic [1:0] ST_SIZE  = 2'd2;

  // address family codes on the result
  localparam logic [1:0] FAM_NONE = 2'd0;
  localparam logic [1:0] FAM_IPV4 = 2'd1;
  localparam logic [1:0] FAM_IPV6 = 2'd2;

  // family byte values on the wire
  localparam logic [7:0] FB_TCP4 = 8'h11;
  localparam logic [7:0] FB_TCP6 = 8'h21;

  localparam logic [3:0] VERSION_2   = 4'h2;
  localparam logic [16:0] MAX_RESET  = 17'd4096;
  localparam int unsigned TDATA_BITS = 328;

  // one incoming byte
  typedef struct packed {
    logic [7:0] data_byte;
    logic       start_of_stream;
  } item_t;

  // one parse result
  typedef struct packed {
    logic [1:0]  status;
    logic        command_kind;
    logic [1:0]  addr_family;
    logic [63:0] src_addr_high;
    logic [63:0] src_addr_low;
    logic [63:0] dst_addr_high;
    logic [63:0] dst_addr_low;
    logic [15:0] src_port;
    logic [15:0] dst_port;
    logic [16:0] header_bytes;
    logic [15:0] tlv_bytes;
  } result_t;

  // v2 signature, twelve bytes
  function automatic logic [7:0] sig_byte(input logic [3:0] idx);
    logic [7:0] b;
    case (idx)
      4'd0:    b = 8'h0d;
      4'd1:    b = 8'h0a;
      4'd2:    b = 8'h0d;
      4'd3:    b = 8'h0a;
      4'd4:    b = 8'h00;
      4'd5:    b = 8'h0d;
      4'd6:    b = 8'h0a;
      4'd7:    b = 8'h51;
      4'd8:    b = 8'h55;
      4'd9:    b = 8'h49;
      4'd10:   b = 8'h54;
      4'd11:   b = 8'h0a;
      default: b = 8'h00;
    endcase
    return b;
  endfunction

endpackage

FILE: src/pvhp_front.sv
`timescale 1ns / 1ps
module pvhp_front
  import pvhp_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  in_valid,
  output logic  in_ready,
  input  item_t in_item,
  output logic  q_valid,
  input  logic  q_pop,
  output item_t q_item
);

  item_t      mem [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       push;
  logic       pop;

  // two-entry request queue
  assign in_ready = (count != 2'd2);
  assign q_valid  = (count != 2'd0);
  assign q_item   = mem[rd_ptr];
  assign push     = in_valid && in_ready;
  assign pop      = q_valid && q_pop;

  // storage write
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= in_item;
    end
  end

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop) rd_ptr <= ~rd_ptr;
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule

FILE: src/pvhp_back.sv
`timescale 1ns / 1ps
module pvhp_back
  import pvhp_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic [16:0] header_limit,
  input  logic        q_valid,
  output logic        q_pop,
  input  item_t       q_item,
  output logic        res_valid,
  input  logic        res_ready,
  output result_t     res
);

  // parse state
  logic [16:0] pos;
  logic [15:0] pl;
  logic        cmd;
  logic [7:0]  fam;
  logic [63:0] src_hi, src_lo, dst_hi, dst_lo;
  logic [15:0] sport, dport;
  logic [1:0]  thc;
  logic [15:0] tvl;
  logic        body_en;
  logic        wide;
  logic [16:0] end_pos;
  logic        fin;

  logic [16:0] pos_next;
  logic [15:0] pl_next;
  logic        cmd_next;
  logic [7:0]  fam_next;
  logic [63:0] src_hi_next, src_lo_next, dst_hi_next, dst_lo_next;
  logic [15:0] sport_next, dport_next;
  logic [1:0]  thc_next;
  logic [15:0] tvl_next;
  logic        body_en_next;
  logic        wide_next;
  logic [16:0] end_pos_next;
  logic        fin_next;

  logic        take;
  logic        emit;
  logic        do_finish;
  logic        st;
  logic [7:0]  b;
  logic [16:0] q;
  logic [16:0] size;
  logic [15:0] pl15;
  logic [5:0]  a1, a2, a3, blk;
  result_t     res_next;

  assign q_pop = !res_valid || res_ready;
  assign take  = q_valid && q_pop;
  assign st    = q_item.start_of_stream;
  assign b     = q_item.data_byte;

  // block boundaries of the address area
  assign a1  = wide_next ? 6'd16 : 6'd4;
  assign a2  = wide_next ? 6'd32 : 6'd8;
  assign a3  = wide_next ? 6'd34 : 6'd10;
  assign blk = wide_next ? 6'd36 : 6'd12;

  // byte step: start clears, then the byte is parsed
  always_comb begin
    pos_next     = st ? 17'd0 : pos;
    pl_next      = st ? 16'd0 : pl;
    cmd_next     = st ? 1'b0 : cmd;
    fam_next     = st ? 8'd0 : fam;
    src_hi_next  = st ? 64'd0 : src_hi;
    src_lo_next  = st ? 64'd0 : src_lo;
    dst_hi_next  = st ? 64'd0 : dst_hi;
    dst_lo_next  = st ? 64'd0 : dst_lo;
    sport_next   = st ? 16'd0 : sport;
    dport_next   = st ? 16'd0 : dport;
    thc_next     = st ? 2'd0 : thc;
    tvl_next     = st ? 16'd0 : tvl;
    body_en_next = st ? 1'b0 : body_en;
    wide_next    = st ? 1'b0 : wide;
    end_pos_next = st ? 17'd0 : end_pos;
    fin_next     = st ? 1'b0 : fin;
    emit         = 1'b0;
    do_finish    = 1'b0;
    res_next     = '0;
    q            = pos_next - 17'd16;
    pl15         = {pl_next[15:8], b};
    size         = 17'd16 + {1'b0, pl15};
    if (!fin_next) begin
      pos_next = pos_next + 17'd1;
      if (pos_next - 17'd1 < 17'd12) begin
        if (b != sig_byte(pos[3:0] & {4{!st}})) begin
          emit            = 1'b1;
          res_next.status = ST_PROTO;
        end
      end else if (pos_next - 17'd1 == 17'd12) begin
        if (b[7:4] != VERSION_2 || b[3:0] > 4'd1) begin
          emit            = 1'b1;
          res_next.status = ST_PROTO;
        end else begin
          cmd_next = b[0];
        end
      end else if (pos_next - 17'd1 == 17'd13) begin
        fam_next = b;
      end else if (pos_next - 17'd1 == 17'd14) begin
        pl_next = {b, 8'h00};
      end else if (pos_next - 17'd1 == 17'd15) begin
        pl_next = pl15;
        if (size > header_limit) begin
          emit            = 1'b1;
          res_next.status = ST_SIZE;
        end else begin
          end_pos_next = {1'b0, pl15} + 17'd15;
          wide_next    = (fam_next == FB_TCP6);
          body_en_next = cmd_next &&
                         ((fam_next == FB_TCP4 && pl15 >= 16'd12) ||
                          (fam_next == FB_TCP6 && pl15 >= 16'd36));
          do_finish    = (pl15 == 16'd0);
        end
      end else begin
        // address block, then tlv chain
        if (body_en_next) begin
          if (q < 17'(a1)) begin
            if (wide_next && q < 17'd8) src_hi_next = {src_hi_next[55:0], b};
            else src_lo_next = {src_lo_next[55:0], b};
          end else if (q < 17'(a2)) begin
            if (wide_next && q < 17'd24) dst_hi_next = {dst_hi_next[55:0], b};
            else dst_lo_next = {dst_lo_next[55:0], b};
          end else if (q < 17'(a3)) begin
            sport_next = {sport_next[7:0], b};
          end else if (q < 17'(blk)) begin
            dport_next = {dport_next[7:0], b};
          end else if (tvl_next != 16'd0 && thc_next == 2'd0) begin
            tvl_next = tvl_next - 16'd1;
          end else if (thc_next == 2'd0) begin
            thc_next = 2'd1;
          end else if (thc_next == 2'd1) begin
            tvl_next = {b, 8'h00};
            thc_next = 2'd2;
          end else begin
            tvl_next = {tvl_next[15:8], b};
            thc_next = 2'd0;
          end
        end
        do_finish = (pos_next - 17'd1 == end_pos_next);
      end
      // header end
      if (do_finish) begin
        emit = 1'b1;
        if (cmd_next) begin
          if (!body_en_next || thc_next != 2'd0 || tvl_next != 16'd0) begin
            res_next.status = ST_PROTO;
          end else begin
            res_next.status         = ST_OK;
            res_next.command_kind   = 1'b1;
            res_next.addr_family    = wide_next ? FAM_IPV6 : FAM_IPV4;
            res_next.src_addr_high  = src_hi_next;
            res_next.src_addr_low   = src_lo_next;
            res_next.dst_addr_high  = dst_hi_next;
            res_next.dst_addr_low   = dst_lo_next;
            res_next.src_port       = sport_next;
            res_next.dst_port       = dport_next;
            res_next.header_bytes   = 17'd16 + {1'b0, pl_next};
            res_next.tlv_bytes      = pl_next - {10'd0, blk};
          end
        end else begin
          res_next.status         = ST_OK;
          res_next.addr_family    = FAM_NONE;
          res_next.header_bytes   = 17'd16 + {1'b0, pl_next};
        end
      end
      if (emit) fin_next = 1'b1;
    end
  end

  // parse state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      pos     <= 17'd0;
      pl      <= 16'd0;
      cmd     <= 1'b0;
      fam     <= 8'd0;
      src_hi  <= 64'd0;
      src_lo  <= 64'd0;
      dst_hi  <= 64'd0;
      dst_lo  <= 64'd0;
      sport   <= 16'd0;
      dport   <= 16'd0;
      thc     <= 2'd0;
      tvl     <= 16'd0;
      body_en <= 1'b0;
      wide    <= 1'b0;
      end_pos <= 17'd0;
      fin     <= 1'b1;
    end else if (take) begin
      pos     <= pos_next;
      pl      <= pl_next;
      cmd     <= cmd_next;
      fam     <= fam_next;
      src_hi  <= src_hi_next;
      src_lo  <= src_lo_next;
      dst_hi  <= dst_hi_next;
      dst_lo  <= dst_lo_next;
      sport   <= sport_next;
      dport   <= dport_next;
      thc     <= thc_next;
      tvl     <= tvl_next;
      body_en <= body_en_next;
      wide    <= wide_next;
      end_pos <= end_pos_next;
      fin     <= fin_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (take && emit) begin
      res_valid <= 1'b1;
    end else if (res_ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take && emit) begin
      res <= res_next;
    end
  end

endmodule

FILE: src/proxy_v2_binary_header_parser_unit.sv
`timescale 1ns / 1ps
// channel   | direction | handshake                     | payload
// s_axis    | in        | s_axis_tvalid / s_axis_tready | tdata: data_byte, tuser: start_of_stream
// m_axis    | out       | m_axis_tvalid / m_axis_tready | tdata: result fields, tuser: status
// cfg       | in        | cfg_valid / cfg_ready         | cfg_data: header size limit
//
// one byte per cycle sustained while m_axis_tready keeps the result register draining; a result
// is registered once its last byte has passed the front queue and been taken by the parser
// the parser pops a byte only while the result register is free or draining
// the two-entry front queue absorbs one byte while the parser stalls; s_axis_tready drops the cycle after
// rst is synchronous; after it the parser ignores bytes until start_of_stream
`include "proxy_v2_binary_header_parser_unit_defines.svh"
module proxy_v2_binary_header_parser_unit
  import pvhp_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    s_axis_tvalid,
  output logic                    s_axis_tready,
  input  logic [7:0]              s_axis_tdata,   // [7:0] data_byte
  input  logic                    s_axis_tuser,   // [0] start_of_stream
  output logic                    m_axis_tvalid,
  input  logic                    m_axis_tready,
  // [0] command_kind, [2:1] addr_family, [66:3] src_addr_high,
  // [130:67] src_addr_low, [194:131] dst_addr_high, [258:195] dst_addr_low,
  // [274:259] src_port, [290:275] dst_port, [307:291] header_bytes,
  // [323:308] tlv_bytes, [327:324] zero
  output logic [TDATA_BITS-1:0]   m_axis_tdata,
  output logic [1:0]              m_axis_tuser,   // [1:0] status
  input  logic                    cfg_valid,
  output logic                    cfg_ready,
  input  logic [16:0]             cfg_data        // [16:0] header size limit
);

  logic [16:0] header_limit;
  item_t       in_item;
  item_t       q_item;
  logic        q_valid;
  logic        q_pop;
  result_t     res;

  // limit register
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      header_limit <= MAX_RESET;
    end else if (cfg_valid) begin
      header_limit <= cfg_data;
    end
  end

  assign in_item.data_byte       = s_axis_tdata;
  assign in_item.start_of_stream = s_axis_tuser;

  // front queue
  pvhp_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .in_item  (in_item),
    .q_valid  (q_valid),
    .q_pop    (q_pop),
    .q_item   (q_item)
  );

  // parser
  pvhp_back u_back (
    .clk          (clk),
    .rst          (rst),
    .header_limit (header_limit),
    .q_valid      (q_valid),
    .q_pop        (q_pop),
    .q_item       (q_item),
    .res_valid    (m_axis_tvalid),
    .res_ready    (m_axis_tready),
    .res          (res)
  );

  // result packing
  assign m_axis_tuser = res.status;
  assign m_axis_tdata = {4'b0000, res.tlv_bytes, res.header_bytes, res.dst_port,
                         res.src_port, res.dst_addr_low, res.dst_addr_high,
                         res.src_addr_low, res.src_addr_high, res.addr_family,
                         res.command_kind};

  // error results carry nothing but the status
  `PVHP_ASSERT_IMPL(a_err_zero, clk, rst, m_axis_tvalid && m_axis_tuser != ST_OK, m_axis_tdata == '0)
  // an address family only comes with a proxy command
  `PVHP_ASSERT_IMPL(a_fam_cmd, clk, rst, m_axis_tvalid && m_axis_tdata[2:1] != FAM_NONE, m_axis_tdata[0] == 1'b1)
  // a limit write lands in the next cycle
  `PVHP_ASSERT_NEXT(a_cfg_write, clk, rst, cfg_valid, header_limit == $past(cfg_data))

endmodule
